// ----- rtl/trms_pkg.sv -----
// Package for the three-phase RMS meter: widths, register indexes, helpers.
// No dependencies; imported by every module of the block.
`default_nettype none
package trms_pkg;
  localparam int ADC_BITS = 12;
  localparam int SUM_W = 34;
  localparam int ROOT_W = 25;
  localparam int CFG_W = 20;
  localparam int NPH = 3;
  localparam logic [1:0] REG_COEFF = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_GAIN = 2'd2;
  localparam logic [7:0] SYNC0 = 8'h55;
  localparam logic [7:0] SYNC1 = 8'hAA;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] VAL_MAX = 16'hFFFF;

  typedef struct packed {
    logic filt_start;   // run filter on phase sel
    logic root_start;   // start square root on phase sel
    logic root_store;   // store scaled value of phase sel
    logic clear;        // clear sums and sample count
    logic [1:0] sel;
  } trms_cmd_t;

  typedef struct packed {
    logic root_done;
    logic window_end;
  } trms_stat_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/trms_if.sv -----
// Valid/ready channel interfaces for sample and frame beats.
// Depends on trms_pkg for widths.
`default_nettype none
interface trms_in_if;
  import trms_pkg::*;
  logic valid;
  logic ready;
  logic [ADC_BITS-1:0] phase_a_plus, phase_a_minus, phase_b_plus;
  logic [ADC_BITS-1:0] phase_b_minus, phase_c_plus, phase_c_minus;
  modport source(output valid, phase_a_plus, phase_a_minus, phase_b_plus,
                 phase_b_minus, phase_c_plus, phase_c_minus, input ready);
  modport sink(input valid, phase_a_plus, phase_a_minus, phase_b_plus,
               phase_b_minus, phase_c_plus, phase_c_minus, output ready);
endinterface

interface trms_out_if;
  logic valid;
  logic ready;
  logic [7:0] frame_byte;
  logic frame_last;
  modport source(output valid, frame_byte, frame_last, input ready);
  modport sink(input valid, frame_byte, frame_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/trms_datapath.sv -----
// Datapath: per-phase filter, square sums, bit-serial root and gain scaling.
// Depends on trms_pkg; driven by trms_ctrl commands.
`default_nettype none
module trms_datapath
  import trms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire trms_pkg::trms_cmd_t cmd,
  output trms_pkg::trms_stat_t stat,
  input  wire logic [ADC_BITS-1:0] smp_plus [NPH],
  input  wire logic [ADC_BITS-1:0] smp_minus [NPH],
  input  wire logic [15:0] coeff,
  input  wire logic [9:0] window,
  input  wire logic [19:0] gain,
  input  wire logic count_step,
  output logic [15:0] value [NPH]
);
  import trms_pkg::*;

  logic signed [15:0] y [NPH];
  logic signed [15:0] rem [NPH];
  logic [SUM_W-1:0] sum [NPH];
  logic [9:0] count;

  // filter stage 1: products registered
  logic signed [ADC_BITS:0] d;
  logic signed [17:0] kk, wk;
  logic signed [35:0] p_y, p_d;
  logic f_ph2;
  logic [1:0] f_sel;
  logic signed [37:0] s;
  logic signed [37:0] t;
  logic signed [15:0] ynew;
  logic signed [31:0] ysq;

  always_comb begin
    d = $signed({1'b0, smp_plus[cmd.sel]}) - $signed({1'b0, smp_minus[cmd.sel]});
    kk = $signed({2'b00, coeff});
    wk = 18'sd32768 - kk;
    s = 38'(p_y) + 38'(p_d);
    t = s + 38'(rem[f_sel]);
    ynew = t[30:15];
    ysq = ynew * ynew;
  end

  // root: restoring bit-serial over 50-bit radicand sum<<16
  logic [SUM_W+15:0] rad;
  logic [ROOT_W:0] root;
  logic [SUM_W+17:0] racc;
  logic [4:0] rstep;
  logic rbusy;
  logic [1:0] rsel;
  logic [ROOT_W+19:0] prod;
  logic [ROOT_W+19:0] scaled;
  logic [SUM_W+17:0] trial;

  always_comb begin
    trial = {racc[SUM_W+15:0], rad[SUM_W+15:SUM_W+14]} - {16'd0, root, 2'b01};
    scaled = (prod + (ROOT_W+20)'(1 << 23)) >> 24;
  end

  always_ff @(posedge clk) begin
    p_y <= wk * 36'(y[cmd.sel]);
    p_d <= kk * 36'(d);
    f_sel <= cmd.sel;
    prod <= root * gain;
    if (rst) begin
      f_ph2 <= 1'b0;
      rbusy <= 1'b0;
      count <= '0;
      for (int i = 0; i < NPH; i++) begin
        y[i] <= '0; rem[i] <= '0; sum[i] <= '0;
      end
    end else begin
      f_ph2 <= cmd.filt_start;
      if (f_ph2) begin
        y[f_sel] <= ynew;
        rem[f_sel] <= 16'(s % 38'sd32768);
        sum[f_sel] <= sum[f_sel] + SUM_W'(unsigned'(ysq));
      end
      if (count_step) count <= count + 10'd1;
      if (cmd.clear) begin
        count <= '0;
        for (int i = 0; i < NPH; i++) sum[i] <= '0;
      end
      if (cmd.root_start) begin
        rbusy <= 1'b1;
        rad <= {sum[cmd.sel], 16'd0};
        racc <= '0;
        root <= '0;
        rstep <= '0;
        rsel <= cmd.sel;
      end else if (rbusy) begin
        rad <= rad << 2;
        if (!trial[SUM_W+17]) begin
          racc <= trial;
          root <= {root[ROOT_W-1:0], 1'b1};
        end else begin
          racc <= {racc[SUM_W+15:0], rad[SUM_W+15:SUM_W+14]};
          root <= {root[ROOT_W-1:0], 1'b0};
        end
        rstep <= rstep + 5'd1;
        if (rstep == 5'd24) rbusy <= 1'b0;
      end
    end
    if (cmd.root_store)
      value[cmd.sel] <= (scaled > (ROOT_W+20)'(VAL_MAX)) ? VAL_MAX : scaled[15:0];
  end

  assign stat.root_done = rbusy && rstep == 5'd24;
  assign stat.window_end = (count == window);
  logic unused;
  assign unused = ^rsel;
endmodule
`default_nettype wire

// ----- rtl/trms_ctrl.sv -----
// Controller: sequences filter steps, window end, root/scale and frame output.
// Depends on trms_pkg.
`default_nettype none
module trms_ctrl
  import trms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_beat,
  output logic in_ready,
  output trms_pkg::trms_cmd_t cmd,
  input  wire trms_pkg::trms_stat_t stat,
  output logic count_step,
  input  wire logic [15:0] value [NPH],
  output logic out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_byte,
  output logic out_last
);
  import trms_pkg::*;
  typedef enum logic [2:0] {IDLE, FILT, CHECK, ROOT, WAIT, SCALE, STORE, SEND} state_t;
  state_t state;
  logic [1:0] ph;
  logic [3:0] idx;
  logic [15:0] crc;
  logic [7:0] b;

  always_comb begin
    case (idx)
      4'd0: b = SYNC0;
      4'd1: b = SYNC1;
      4'd2: b = value[0][7:0];
      4'd3: b = value[0][15:8];
      4'd4: b = value[1][7:0];
      4'd5: b = value[1][15:8];
      4'd6: b = value[2][7:0];
      4'd7: b = value[2][15:8];
      4'd8: b = crc[7:0];
      default: b = crc[15:8];
    endcase
  end

  assign in_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    cmd <= '0;
    count_step <= 1'b0;
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      ph <= '0;
    end else begin
      case (state)
        IDLE: if (in_beat) begin
          cmd.filt_start <= 1'b1; cmd.sel <= 2'd0; ph <= 2'd1; state <= FILT;
        end
        FILT: begin
          if (ph == 2'd3) begin
            state <= CHECK;
          end else begin
            cmd.filt_start <= 1'b1; cmd.sel <= ph; ph <= ph + 2'd1;
            // step the count with the last filter command so it settles before CHECK
            if (ph == 2'd2) count_step <= 1'b1;
          end
        end
        CHECK: begin
          // count has settled; last filter lands on this edge
          if (stat.window_end) begin
            ph <= 2'd0; state <= ROOT;
          end else state <= IDLE;
        end
        ROOT: begin
          cmd.root_start <= 1'b1; cmd.sel <= ph; state <= WAIT;
        end
        WAIT: if (stat.root_done) state <= SCALE;
        SCALE: state <= STORE;
        STORE: begin
          cmd.root_store <= 1'b1; cmd.sel <= ph;
          if (ph == 2'd2) begin
            cmd.clear <= 1'b1; idx <= '0; crc <= CRC_INIT; state <= SEND;
          end else begin
            ph <= ph + 2'd1; state <= ROOT;
          end
        end
        SEND: begin
          if (!out_valid) begin
            out_valid <= 1'b1; out_byte <= b; out_last <= (idx == 4'd9);
          end else if (out_ready) begin
            if (idx < 4'd8) crc <= crc_update(crc, out_byte);
            if (out_last) begin
              out_valid <= 1'b0; state <= IDLE;
            end else begin
              out_valid <= 1'b0;
            end
            idx <= idx + 4'd1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == SEND);
  assert property (@(posedge clk) disable iff (rst) in_beat |=> state == FILT);
  assert property (@(posedge clk) disable iff (rst) out_valid && out_last && out_ready
                   |=> state == IDLE);
endmodule
`default_nettype wire

// ----- rtl/three_phase_rms_meter.sv -----
// Top level of the three-phase RMS meter; ties controller and datapath.
// Depends on trms_pkg, trms_if, trms_ctrl, trms_datapath.
//
// Usage: samples arrive as beats on "samples" (six ADC codes). For each
// beat, three filter updates share one multiplier pair, one phase per
// cycle, then a window check follows before ready returns. At window end
// the block computes three square roots bit-serially (25 steps each) plus
// scaling, then emits ten frame beats on "frame", one at a time; a stalled
// receiver simply holds the beat. No sample is taken until the frame's
// last beat leaves. Configuration writes on cfg_we/cfg_index/cfg_data
// land at once and must only happen while idle.
// Reset (rst, synchronous) loads register defaults and clears filter
// state, sums and the sample count.
`default_nettype none
module three_phase_rms_meter
  import trms_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  trms_in_if.sink samples,
  trms_out_if.source frame,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [CFG_W-1:0] cfg_data
);
  import trms_pkg::*;
  logic [15:0] coeff;
  logic [9:0] window;
  logic [19:0] gain;
  trms_cmd_t cmd;
  trms_stat_t stat;
  logic count_step;
  logic [15:0] value [NPH];
  logic [ADC_BITS-1:0] sp [NPH];
  logic [ADC_BITS-1:0] sm [NPH];
  logic [ADC_BITS-1:0] sp_q [NPH];
  logic [ADC_BITS-1:0] sm_q [NPH];
  logic in_beat;

  assign in_beat = samples.valid && samples.ready;
  assign sp[0] = samples.phase_a_plus;  assign sm[0] = samples.phase_a_minus;
  assign sp[1] = samples.phase_b_plus;  assign sm[1] = samples.phase_b_minus;
  assign sp[2] = samples.phase_c_plus;  assign sm[2] = samples.phase_c_minus;

  // hold the sample beat for the filter pass
  always_ff @(posedge clk) begin
    if (in_beat) begin
      sp_q <= sp; sm_q <= sm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= 16'd1544; window <= 10'd400; gain <= 20'd97560;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEFF: coeff <= cfg_data[15:0];
        REG_WINDOW: window <= cfg_data[9:0];
        REG_GAIN: gain <= cfg_data;
        default: ;
      endcase
    end
  end

  trms_ctrl u_ctrl (
    .clk, .rst, .in_beat, .in_ready(samples.ready), .cmd, .stat, .count_step,
    .value, .out_valid(frame.valid), .out_ready(frame.ready),
    .out_byte(frame.frame_byte), .out_last(frame.frame_last)
  );

  trms_datapath u_dp (
    .clk, .rst, .cmd, .stat, .smp_plus(sp_q), .smp_minus(sm_q),
    .coeff, .window, .gain, .count_step, .value
  );
endmodule
`default_nettype wire

// ----- tb/sv/three_phase_rms_meter_tb.sv -----
// Self-checking testbench for the three-phase RMS meter: drives sample beats,
// predicts the 10-byte CRC-16 report frames and checks every frame beat.
// Depends on trms_pkg, trms_if and the three_phase_rms_meter RTL.
`default_nettype none
module three_phase_rms_meter_tb;
  import trms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef struct {
    logic [ADC_BITS-1:0] s[6];
  } sample_set_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  trms_in_if samples_ch();
  trms_out_if frame_ch();

  three_phase_rms_meter dut (
    .clk(clk), .rst(rst), .samples(samples_ch.sink), .frame(frame_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: filter, sums, count and the configuration copy.
  logic [15:0] coeff_q;
  logic [9:0] window_q;
  logic [19:0] gain_q;
  logic signed [15:0] filt_y[3];
  logic signed [15:0] filt_rem[3];
  logic [33:0] sq_sum[3];
  logic [9:0] sample_cnt;

  frame_beat_t frame_queue[$];
  int errors;
  int beats_sent;
  int frames_seen;
  int bytes_seen;
  int idle_cycles;
  bit long_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [24:0] int_sqrt(input logic [49:0] v);
    logic [49:0] rest;
    logic [49:0] root;
    logic [49:0] bitv;
    rest = v;
    root = '0;
    bitv = 50'd1 << 48;
    while (bitv > rest) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[24:0];
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic void cfg_model(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_COEFF: coeff_q = val[15:0];
      REG_WINDOW: window_q = val[9:0];
      REG_GAIN: gain_q = val;
      default: ;
    endcase
  endfunction

  // Advance the meter model by one sample beat; queue the report frame if due.
  function automatic void predict_meter(input sample_set_t smp);
    longint d, k, y, s, t;
    logic [7:0] fr[10];
    logic [15:0] crc;
    logic [24:0] root;
    longint unsigned v;
    for (int p = 0; p < 3; p++) begin
      d = longint'(smp.s[2*p]) - longint'(smp.s[2*p+1]);
      k = longint'(coeff_q);
      y = longint'(filt_y[p]);
      s = (32768 - k) * y + k * d;
      t = (s + longint'(filt_rem[p])) >>> 15;
      filt_rem[p] = 16'(s % 32768);
      filt_y[p] = t[15:0];
      sq_sum[p] = sq_sum[p] + 34'(longint'(filt_y[p]) * longint'(filt_y[p]));
    end
    sample_cnt = sample_cnt + 10'd1;
    if (sample_cnt != window_q) return;
    fr[0] = SYNC0;
    fr[1] = SYNC1;
    for (int p = 0; p < 3; p++) begin
      root = int_sqrt({sq_sum[p], 16'd0});
      v = (longint'(root) * longint'(gain_q) + (64'd1 << 23)) >> 24;
      if (v > 65535) v = 65535;
      fr[2+2*p] = v[7:0];
      fr[3+2*p] = v[15:8];
      sq_sum[p] = '0;
    end
    crc = CRC_INIT;
    for (int n = 0; n < 8; n++) crc = crc16_byte(crc, fr[n]);
    fr[8] = crc[7:0];
    fr[9] = crc[15:8];
    sample_cnt = '0;
    for (int n = 0; n < 10; n++) frame_queue.push_back('{fr[n], n == 9});
  endfunction

  // Receiver: stall on its own pattern, with one long hold-off on request.
  initial begin
    frame_ch.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (long_stall) begin
        frame_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_stall = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: frame_ch.ready <= 1'b1;
        1: frame_ch.ready <= ($urandom_range(0, 3) != 0);
        default: frame_ch.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // Check each accepted frame beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      bytes_seen++;
      if (frame_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame beat byte=%02h last=%0b", $time,
                 frame_ch.frame_byte, frame_ch.frame_last);
      end else begin
        frame_beat_t exp_b;
        exp_b = frame_queue.pop_front();
        if (exp_b.data !== frame_ch.frame_byte) begin
          errors++;
          $display("%0t: frame_byte expected %02h actual %02h", $time, exp_b.data,
                   frame_ch.frame_byte);
        end
        if (exp_b.last !== frame_ch.frame_last) begin
          errors++;
          $display("%0t: frame_last expected %0b actual %0b", $time, exp_b.last,
                   frame_ch.frame_last);
        end
        if (exp_b.last) frames_seen++;
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) || (frame_ch.valid && frame_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d beats still expected", $time, frame_queue.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one sample beat, hold it until accepted, then predict.
  task automatic send_samples(input sample_set_t smp, input bit keep_valid);
    samples_ch.valid <= 1'b1;
    samples_ch.phase_a_plus <= smp.s[0];
    samples_ch.phase_a_minus <= smp.s[1];
    samples_ch.phase_b_plus <= smp.s[2];
    samples_ch.phase_b_minus <= smp.s[3];
    samples_ch.phase_c_plus <= smp.s[4];
    samples_ch.phase_c_minus <= smp.s[5];
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    predict_meter(smp);
    beats_sent++;
    if (!keep_valid) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_model(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every expected beat, then let the pipeline settle before a write.
  task automatic wait_idle();
    while (frame_queue.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic sample_set_t rand_samples(input int mode);
    sample_set_t r;
    for (int i = 0; i < 6; i++) begin
      case (mode)
        0: r.s[i] = (i % 2 == 0) ? 12'hFFF : 12'h000;
        1: r.s[i] = (i % 2 == 0) ? 12'h000 : 12'hFFF;
        2: r.s[i] = 12'($urandom_range(1800, 2300));
        default: r.s[i] = 12'($urandom);
      endcase
    end
    return r;
  endfunction

  // Random bursts with gaps; mode picks extremes now and then.
  task automatic random_burst(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len && sent < count; i++) begin
        send_samples(rand_samples($urandom_range(0, 9) < 2 ? $urandom_range(0, 1) :
                                  $urandom_range(2, 3)), i != len - 1 && sent != count - 1);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Directed rows: six samples each.
  typedef struct {
    logic [ADC_BITS-1:0] s[6];
  } dir_row_t;

  initial begin
    dir_row_t rows[8];
    sample_set_t smp;
    errors = 0;
    beats_sent = 0;
    frames_seen = 0;
    bytes_seen = 0;
    long_stall = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_COEFF;
    cfg_data = '0;
    samples_ch.valid = 1'b0;
    samples_ch.phase_a_plus = '0;
    samples_ch.phase_a_minus = '0;
    samples_ch.phase_b_plus = '0;
    samples_ch.phase_b_minus = '0;
    samples_ch.phase_c_plus = '0;
    samples_ch.phase_c_minus = '0;
    cfg_model(REG_COEFF, 20'd1544);
    cfg_model(REG_WINDOW, 20'd400);
    cfg_model(REG_GAIN, 20'd97560);
    for (int p = 0; p < 3; p++) begin
      filt_y[p] = '0;
      filt_rem[p] = '0;
      sq_sum[p] = '0;
    end
    sample_cnt = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Window of one with zero input: the frame after reset is all zero values.
    write_reg(REG_WINDOW, 20'd1);
    smp.s = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
    send_samples(smp, 1'b0);
    if (frame_queue.size() != 10 || frame_queue[2].data != 8'h00 || frame_queue[0].data != SYNC0)
      begin
      errors++;
      $display("%0t: predicted reset frame malformed expected 55 AA 00.. actual %02h", $time,
               frame_queue[0].data);
    end
    wait_idle();

    // Extremes: full-scale differences of both signs, full coefficient, top gain.
    write_reg(REG_COEFF, 20'd32768);
    write_reg(REG_GAIN, 20'hFFFFF);
    rows[0].s = '{12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF};
    rows[1].s = '{12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h800, 12'h7FF};
    rows[2].s = '{12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'h001, 12'hFFE};
    rows[3].s = '{12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h000, 12'hFFF};
    for (int i = 0; i < 4; i++) begin
      smp.s = rows[i].s;
      send_samples(smp, 1'b0);
    end
    wait_idle();
    // Coefficient above 32768 (negative weight) and zero gain, window 3.
    write_reg(REG_COEFF, 20'hFFFF);
    write_reg(REG_GAIN, 20'd0);
    write_reg(REG_WINDOW, 20'd3);
    for (int i = 0; i < 6; i++) send_samples(rand_samples(i % 2), 1'b0);
    wait_idle();
    write_reg(REG_COEFF, 20'd40000);
    write_reg(REG_GAIN, 20'd97560);
    for (int i = 0; i < 6; i++) send_samples(rand_samples(3), 1'b0);
    wait_idle();
    // Coefficient zero holds the filter; window lowered mid-count still reports.
    write_reg(REG_COEFF, 20'd0);
    write_reg(REG_WINDOW, 20'd5);
    for (int i = 0; i < 2; i++) send_samples(rand_samples(3), 1'b0);
    wait_idle();
    write_reg(REG_COEFF, 20'd1544);
    write_reg(REG_WINDOW, 20'd3);
    send_samples(rand_samples(3), 1'b0);

    // Random part across several settings; long receiver stall in the first.
    wait_idle();
    write_reg(REG_WINDOW, 20'd4);
    write_reg(REG_GAIN, 20'($urandom_range(0, 20'hFFFFF)));
    long_stall = 1'b1;
    random_burst(60);
    wait_idle();
    write_reg(REG_COEFF, 20'($urandom_range(1, 32768)));
    write_reg(REG_WINDOW, 20'd7);
    write_reg(REG_GAIN, 20'($urandom_range(50000, 300000)));
    random_burst(77);
    wait_idle();
    write_reg(REG_COEFF, 20'($urandom_range(0, 65535)));
    write_reg(REG_WINDOW, 20'd2);
    random_burst(60);
    wait_idle();
    // Larger window for a big-sum frame.
    write_reg(REG_COEFF, 20'd32768);
    write_reg(REG_WINDOW, 20'd30);
    write_reg(REG_GAIN, 20'hFFFFF);
    random_burst(60);

    while (frame_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Run covered %0d sample beats, %0d report frames, %0d frame bytes checked.",
             beats_sent, frames_seen, bytes_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
